/* design/wsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsm_pkg;

   localparam int WINDOW_DEPTH   = 17;
   localparam int SIG_COUNT      = 9;
   localparam int SIG_BASE_COUNT = 7;
   localparam int SIG_MAX_LEN    = WINDOW_DEPTH + 1;
   localparam int MASK_WIDTH     = 11;
   localparam int MASK_AGENT     = 9;
   localparam int MASK_COOKIE    = 10;
   localparam int SCORE_WIDTH    = 5;
   localparam int CSR_WIDTH      = 4;

   // low byte of each entry holds the final character of the signature
   localparam logic [8*SIG_MAX_LEN-1:0] SIG_TEXT [SIG_COUNT] = '{
      "<script",
      "%3cscript",
      "union select",
      "../",
      "' or 1=1",
      "sleep(",
      "benchmark(",
      "%2e%2e%2f",
      {"information_", "schema"}
   };

   localparam logic [4:0] SIG_LEN [SIG_COUNT] = '{
      5'd7, 5'd9, 5'd12, 5'd3, 5'd8, 5'd6, 5'd10, 5'd9, 5'd18
   };

   localparam logic [1:0] SIG_WEIGHT [SIG_COUNT] = '{
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3
   };

   typedef enum logic [2:0] {
      CSR_ENABLED        = 3'd0,
      CSR_PARANOIA_LEVEL = 3'd1,
      CSR_EXTRA_RULES_ON = 3'd2,
      CSR_CHECK_AGENT    = 3'd3,
      CSR_CHECK_COOKIE   = 3'd4,
      CSR_DETECT_ONLY    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SIG_COUNT-1:0]      care;
      logic [SIG_COUNT-1:0][7:0] char_code;
   } pattern_type;

   typedef struct packed {
      logic advance;
      logic flush;
   } cell_ctrl_type;

   // expected characters for the byte that lies k positions behind the current one
   function automatic pattern_type sig_pattern(input int k);
      pattern_type p;
      for (int i = 0; i < SIG_COUNT; i++) begin
         p.char_code[i] = SIG_TEXT[i][8*k +: 8];
         p.care[i]      = (5'(k) < SIG_LEN[i]);
      end
      return p;
   endfunction

endpackage

`default_nettype wire

/* design/wsm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsm_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wsm_pkg::cell_ctrl_type       ctrl,
   input  wsm_pkg::pattern_type         pattern,
   input  wire  [7:0]                   shift_byte,
   output logic [7:0]                   byte_out,
   output logic [wsm_pkg::SIG_COUNT-1:0] hit
);
   import wsm_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.advance) begin
         byte_in = ctrl.flush ? 8'h00 : shift_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in;
      end
   end

   always_comb begin
      for (int i = 0; i < SIG_COUNT; i++) begin
         hit[i] = !pattern.care[i] || (byte_ff == pattern.char_code[i]);
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

/* design/weighted_signature_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// The result is registered and presented in the cycle after the last byte of a request is taken.
// Throughput: one byte per cycle while req_stall is low; every byte is compared against all signatures at once
// across the 17 window cells and the current byte.
// Input is held off only while a result waits and the output side stalls.
// Reset (synchronous) clears the window, hit flags and output valid and loads register defaults.
module weighted_signature_matcher (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [7:0]                     req_data_byte,
   input  wire                            req_last_byte,
   input  wire                            req_agent_empty,
   input  wire                            req_cookie_present,
   input  wire                            req_path_sensitive,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [wsm_pkg::SCORE_WIDTH-1:0] rsp_score,
   output logic [1:0]                     rsp_threshold,
   output logic                           rsp_block,
   output logic [wsm_pkg::MASK_WIDTH-1:0] rsp_match_mask,
   input  wire                            csr_write_enable,
   input  wire  [2:0]                     csr_index,
   input  wire  [wsm_pkg::CSR_WIDTH-1:0]  csr_data
);
   import wsm_pkg::*;

   logic       enabled_ff;
   logic [3:0] paranoia_level_ff;
   logic       extra_rules_on_ff;
   logic       check_agent_ff;
   logic       check_cookie_ff;
   logic       detect_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff        <= 1'b0;
         paranoia_level_ff <= 4'd1;
         extra_rules_on_ff <= 1'b0;
         check_agent_ff    <= 1'b0;
         check_cookie_ff   <= 1'b0;
         detect_only_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLED:        enabled_ff        <= csr_data[0];
            CSR_PARANOIA_LEVEL: paranoia_level_ff <= csr_data[3:0];
            CSR_EXTRA_RULES_ON: extra_rules_on_ff <= csr_data[0];
            CSR_CHECK_AGENT:    check_agent_ff    <= csr_data[0];
            CSR_CHECK_COOKIE:   check_cookie_ff   <= csr_data[0];
            CSR_DETECT_ONLY:    detect_only_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic accept;
   logic finish;
   logic rsp_valid_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign finish    = accept && req_last_byte;

   logic [7:0] cur_byte;

   always_comb begin
      cur_byte = req_data_byte;
      if (req_data_byte >= 8'h41 && req_data_byte <= 8'h5A) begin
         cur_byte = req_data_byte | 8'h20;
      end
   end

   cell_ctrl_type              cell_ctrl;
   logic [7:0]                 chain [WINDOW_DEPTH+1];
   logic [SIG_COUNT-1:0]       cell_hit [WINDOW_DEPTH];

   assign cell_ctrl.advance = accept;
   assign cell_ctrl.flush   = req_last_byte;
   assign chain[0]          = cur_byte;

   for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_cell
      wsm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .pattern    (sig_pattern(j + 1)),
         .shift_byte (chain[j]),
         .byte_out   (chain[j+1]),
         .hit        (cell_hit[j])
      );
   end

   pattern_type          head_pattern;
   logic [SIG_COUNT-1:0] match;

   assign head_pattern = sig_pattern(0);

   always_comb begin
      for (int i = 0; i < SIG_COUNT; i++) begin
         match[i] = (cur_byte == head_pattern.char_code[i]);
         for (int j = 0; j < WINDOW_DEPTH; j++) begin
            match[i] = match[i] && cell_hit[j][i];
         end
      end
   end

   logic [SIG_COUNT-1:0] hits_ff;
   logic [SIG_COUNT-1:0] hits_in;

   assign hits_in = hits_ff | match;

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff <= '0;
      end else if (accept) begin
         hits_ff <= req_last_byte ? '0 : hits_in;
      end
   end

   logic [SCORE_WIDTH-1:0] score_in;
   logic [1:0]             threshold_in;
   logic                   block_in;
   logic [MASK_WIDTH-1:0]  mask_in;

   always_comb begin
      score_in     = '0;
      threshold_in = 2'd0;
      block_in     = 1'b0;
      mask_in      = '0;
      if (enabled_ff) begin
         if (paranoia_level_ff >= 4'd4) begin
            threshold_in = 2'd1;
         end else if (paranoia_level_ff == 4'd3) begin
            threshold_in = 2'd2;
         end else begin
            threshold_in = 2'd3;
         end
         for (int i = 0; i < SIG_COUNT; i++) begin
            if (hits_in[i] && (i < SIG_BASE_COUNT || extra_rules_on_ff)) begin
               mask_in[i] = 1'b1;
               score_in   = score_in + {3'b000, SIG_WEIGHT[i]};
            end
         end
         if (check_agent_ff && req_agent_empty) begin
            mask_in[MASK_AGENT] = 1'b1;
            score_in            = score_in + 5'd1;
         end
         if (check_cookie_ff && !req_cookie_present && req_path_sensitive) begin
            mask_in[MASK_COOKIE] = 1'b1;
            score_in             = score_in + 5'd1;
         end
         block_in = !detect_only_ff && (score_in >= {3'b000, threshold_in});
      end
   end

   logic [SCORE_WIDTH-1:0] score_ff;
   logic [1:0]             threshold_ff;
   logic                   block_ff;
   logic [MASK_WIDTH-1:0]  mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         score_ff     <= score_in;
         threshold_ff <= threshold_in;
         block_ff     <= block_in;
         mask_ff      <= mask_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_score      = score_ff;
   assign rsp_threshold  = threshold_ff;
   assign rsp_block      = block_ff;
   assign rsp_match_mask = mask_ff;

endmodule

`default_nettype wire
